[design/vtx_pkg.sv]
// ----------------------------------------------------------------------------
// vtx_pkg: shared types and constants of the vertex transform unit
// Fixed-point formats, word layouts, operation codes and the lane control group.
// ----------------------------------------------------------------------------
package vtx_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int ELEM_WIDTH  = 32;
    localparam int COMP_W      = 32;
    localparam int NUM_ROWS    = 4;
    localparam int NUM_COLS    = 4;
    localparam int NUM_REGS    = 8;
    localparam int REG_W       = 64;
    localparam int HALF_W      = 32;
    localparam int IDX_W       = $clog2(NUM_REGS);
    localparam int OP_W        = 2;
    localparam int PROD_W      = ELEM_WIDTH + COMP_W;
    localparam int PAIR_W      = PROD_W + 1;
    localparam int SUM_W       = PROD_W + 2;
    localparam int IN_FIELDS_W = OP_W + NUM_COLS * COMP_W;
    localparam int OUT_FIELDS_W = NUM_ROWS * COMP_W + 1;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_FULL   = 2'd0,
        OP_POINT  = 2'd1,
        OP_ROTATE = 2'd2
    } op_t;

    typedef logic signed [COMP_W-1:0]     comp_t;
    typedef logic signed [ELEM_WIDTH-1:0] elem_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [PAIR_W-1:0]     pair_t;
    typedef logic signed [SUM_W-1:0]      sum_t;
    typedef logic [REG_W-1:0]             cfg_word_t;

    typedef struct packed {
        logic prod_en;
        logic pair_en;
        logic sum_en;
    } lane_ctrl_t;

    localparam comp_t ONE_FIXED = comp_t'(64'd1 << FRAC_BITS);

    localparam cfg_word_t CFG_RESET [NUM_REGS] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

endpackage

[design/vertex_transform_4x4_unit.sv]
// ----------------------------------------------------------------------------
// vertex_transform_4x4_unit: 4x4 matrix by vector transform, signed Q16.16
// Four row lanes work side by side; a merge stage builds the result word.
// ----------------------------------------------------------------------------
// The unit takes one vector word per clock and returns one result word per
// clock while the output is not stalled.
// The five register stages are the input register, the four multipliers of
// each row lane, the pair sums, the final sum with shift and clamp, and the
// output register; every stage holds its word while the next one is full, so
// input words keep flowing into empty stages while a result waits at the output.
// The user is to write matrix registers through the configuration port only
// while the unit is idle (unchecked); they come out of reset as the identity.
module vertex_transform_4x4_unit
    import vtx_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [IDX_W-1:0]       cfg_index,
    input  logic [REG_W-1:0]       cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // op, in_x, in_y, in_z, in_w from bit 0 up
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // out_x, out_y, out_z, out_w, saturated from bit 0 up
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    cfg_word_t cfg_reg [NUM_REGS];

    logic  v0_reg, v1_reg, v2_reg, v3_reg;
    logic  w0_reg, w1_reg, w2_reg, w3_reg;
    comp_t vec_reg [NUM_COLS];

    logic  free0, free1, free2, free3, free4;
    op_t   in_op;
    comp_t in_w_next;
    logic  w_used_next;

    lane_ctrl_t          lane_ctrl;
    comp_t               lane_result [NUM_ROWS];
    logic [NUM_ROWS-1:0] lane_clamped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    assign free4 = !m_axis_tvalid || m_axis_tready;
    assign free3 = !v3_reg || free4;
    assign free2 = !v2_reg || free3;
    assign free1 = !v1_reg || free2;
    assign free0 = !v0_reg || free1;
    assign s_axis_tready = free0;

    always_comb
    begin
        in_op = op_t'(s_axis_tdata[OP_W-1:0]);
        case (in_op)
            OP_POINT:
            begin
                in_w_next   = ONE_FIXED;
                w_used_next = 1'b0;
            end
            OP_ROTATE:
            begin
                in_w_next   = comp_t'(0);
                w_used_next = 1'b0;
            end
            default:
            begin
                in_w_next   = s_axis_tdata[OP_W + 3*COMP_W +: COMP_W];
                w_used_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (free0)
            begin
                v0_reg <= s_axis_tvalid;
            end
            if (free1)
            begin
                v1_reg <= v0_reg;
            end
            if (free2)
            begin
                v2_reg <= v1_reg;
            end
            if (free3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (free0)
        begin
            for (int c = 0; c < NUM_COLS - 1; c++)
            begin
                vec_reg[c] <= s_axis_tdata[OP_W + c*COMP_W +: COMP_W];
            end
            vec_reg[NUM_COLS-1] <= in_w_next;
            w0_reg              <= w_used_next;
        end
        if (free1)
        begin
            w1_reg <= w0_reg;
        end
        if (free2)
        begin
            w2_reg <= w1_reg;
        end
        if (free3)
        begin
            w3_reg <= w2_reg;
        end
    end

    assign lane_ctrl.prod_en = free1;
    assign lane_ctrl.pair_en = free2;
    assign lane_ctrl.sum_en  = free3;

    for (genvar r = 0; r < NUM_ROWS; r++)
    begin : g_lane
        elem_t row_elem [NUM_COLS];

        for (genvar c = 0; c < NUM_COLS; c++)
        begin : g_elem
            assign row_elem[c] = cfg_reg[2*r + c/2][HALF_W*(c%2) +: ELEM_WIDTH];
        end

        vtx_row_lane u_lane (
            .clk      (clk),
            .ctrl     (lane_ctrl),
            .row_elem (row_elem),
            .vec      (vec_reg),
            .result   (lane_result[r]),
            .clamped  (lane_clamped[r])
        );
    end

    vtx_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (free4),
        .in_valid     (v3_reg),
        .w_used       (w3_reg),
        .lane_result  (lane_result),
        .lane_clamped (lane_clamped),
        .out_valid    (m_axis_tvalid),
        .out_data     (m_axis_tdata)
    );

endmodule

[design/vtx_row_lane.sv]
// ----------------------------------------------------------------------------
// vtx_row_lane: one matrix row dotted with the vector
// Four registered products, a registered pair sum, then the final sum with an
// arithmetic shift by the fraction width and clamping to the element range.
// ----------------------------------------------------------------------------
module vtx_row_lane
    import vtx_pkg::*;
(
    input  logic       clk,
    input  lane_ctrl_t ctrl,
    input  elem_t      row_elem [NUM_COLS],
    input  comp_t      vec [NUM_COLS],
    output comp_t      result,
    output logic       clamped
);

    localparam sum_t ELEM_MAX = sum_t'({1'b0, {(ELEM_WIDTH-1){1'b1}}});
    localparam sum_t ELEM_MIN = -ELEM_MAX - sum_t'(1);

    prod_t prod_reg [NUM_COLS];
    pair_t pair_reg [2];
    comp_t result_reg;
    logic  clamped_reg;

    sum_t  sum_full;
    sum_t  shifted;
    sum_t  limited;
    logic  clamped_next;
    comp_t result_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.prod_en)
        begin
            for (int c = 0; c < NUM_COLS; c++)
            begin
                prod_reg[c] <= prod_t'(row_elem[c]) * prod_t'(vec[c]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.pair_en)
        begin
            pair_reg[0] <= pair_t'(prod_reg[0]) + pair_t'(prod_reg[1]);
            pair_reg[1] <= pair_t'(prod_reg[2]) + pair_t'(prod_reg[3]);
        end
    end

    always_comb
    begin
        sum_full     = sum_t'(pair_reg[0]) + sum_t'(pair_reg[1]);
        shifted      = sum_full >>> FRAC_BITS;
        limited      = shifted;
        clamped_next = 1'b0;
        if (shifted > ELEM_MAX)
        begin
            limited      = ELEM_MAX;
            clamped_next = 1'b1;
        end
        else if (shifted < ELEM_MIN)
        begin
            limited      = ELEM_MIN;
            clamped_next = 1'b1;
        end
        result_next = comp_t'(elem_t'(limited));
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.sum_en)
        begin
            result_reg  <= result_next;
            clamped_reg <= clamped_next;
        end
    end

    assign result  = result_reg;
    assign clamped = clamped_reg;

endmodule

[design/vtx_merge.sv]
// ----------------------------------------------------------------------------
// vtx_merge: output stage
// Combines the four lane results into one result word, forces w to zero when
// the operation has no w row, and merges the clamp flags.
// ----------------------------------------------------------------------------
module vtx_merge
    import vtx_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  logic                   in_valid,
    input  logic                   w_used,
    input  comp_t                  lane_result [NUM_ROWS],
    input  logic [NUM_ROWS-1:0]    lane_clamped,
    output logic                   out_valid,
    output logic [OUT_TDATA_W-1:0] out_data
);

    logic                   valid_reg;
    logic                   valid_next;
    logic [OUT_TDATA_W-1:0] data_reg;
    logic [OUT_TDATA_W-1:0] data_next;
    comp_t                  w_value;
    logic                   sat;

    always_comb
    begin
        w_value    = w_used ? lane_result[NUM_ROWS-1] : comp_t'(0);
        sat        = (|lane_clamped[NUM_ROWS-2:0]) | (w_used & lane_clamped[NUM_ROWS-1]);
        data_next  = OUT_TDATA_W'({sat, w_value, lane_result[2], lane_result[1],
                                   lane_result[0]});
        valid_next = load ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[design/vtx_checker.sv]
// ----------------------------------------------------------------------------
// vtx_checker: port-level checks of the vertex transform unit
// Output hold under stall and the relation between input and output flow.
// ----------------------------------------------------------------------------
module vtx_checker
    import vtx_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed or dropped while stalled");

    a_ready_needs_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input blocked although the output is not stalled");

    a_full_stays_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready && !m_axis_tready |=> s_axis_tready == m_axis_tready)
    else $error("input ready of the full pipeline does not follow the output ready");

endmodule

bind vertex_transform_4x4_unit vtx_checker u_vtx_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
